>>> src/pcpg_pkg.sv
// shared types, constants and the cordic arctangent table for the circle generator
`timescale 1ns / 1ps
`default_nettype none
package pcpg_pkg;

    // default sizes
    localparam int COORD_BITS_DEF   = 11;
    localparam int FRAC_BITS_DEF    = 20;
    localparam int CORDIC_ITERS_DEF = 32;

    // angle format is q2.30
    localparam int ANG_FRAC = 30;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam logic [31:0] ONE_Q30     = 32'h40000000;

    // item codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // one queued item
    typedef struct packed {
        logic        func;
        logic [10:0] center_x;
        logic [10:0] center_y;
        logic [10:0] radius;
    } t_item;

    // arctangent of 2^-i in q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/pcpg_fifo.sv
// two-entry item queue between the front and the drawing engine
`timescale 1ns / 1ps
`default_nettype none
module pcpg_fifo
    import pcpg_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_full,
    input  wire   i_pop,
    output t_item o_item,
    output logic  o_valid
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

>>> src/pcpg_engine.sv
// back end: reciprocal divide, cordic, rotation and eight-way pixel output
`timescale 1ns / 1ps
`default_nettype none
module pcpg_engine
    import pcpg_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_item             i_item,
    input  wire               i_item_valid,
    output logic              o_pop,
    input  wire        [23:0] i_color,
    input  wire               i_stall,
    output logic              o_valid,
    output logic signed [12:0] o_pixel_x,
    output logic signed [12:0] o_pixel_y,
    output logic       [23:0] o_color,
    output logic              o_last_of_run,
    output logic              o_circle_done
);

    localparam int CB  = COORD_BITS;
    localparam int PB  = COORD_BITS + FRAC_BITS + 2;   // position width
    localparam int PLO = (PB + 1) / 2;                 // low slice of a position
    localparam int PM  = PLO + 1 + 32;                 // partial product width
    localparam int AW  = PB + 34;                      // accumulator width
    localparam int VW  = AW - ANG_FRAC;                // rounded sum width
    localparam int RW  = CB + 3;                       // rounded pixel offset width
    localparam int OW  = (CB + 4 > 13) ? CB + 4 : 13;  // pixel sum width
    // iteration counter must also hold the table length
    localparam int IW  = ($clog2(CORDIC_ITERS + 1) > 6) ? $clog2(CORDIC_ITERS + 1) : 6;
    localparam int CW  = 34;                           // cordic datapath width

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_CORD, S_ROT, S_FIN, S_RND, S_EMIT, S_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_active;
    logic [CB-1:0]           r_ccol;
    logic [CB-1:0]           r_crow;
    logic [CB-1:0]           r_rad;
    logic signed [PB-1:0]    r_pos_x;
    logic signed [PB-1:0]    r_pos_y;
    logic signed [31:0]      r_cos;
    logic signed [31:0]      r_sin;
    logic [CB:0]             r_rem;
    logic [ANG_FRAC-1:0]     r_quo;
    logic [4:0]              r_dcnt;
    logic signed [CW-1:0]    r_cx;
    logic signed [CW-1:0]    r_cy;
    logic signed [CW-1:0]    r_cz;
    logic [IW-1:0]           r_iter;
    logic [3:0]              r_step;
    logic signed [PM-1:0]    r_prod;
    logic [2:0]              r_tag;
    logic                    r_pv;
    logic signed [AW-1:0]    r_acc_x;
    logic signed [AW-1:0]    r_acc_y;
    logic signed [RW-1:0]    r_rx;
    logic signed [RW-1:0]    r_ry;
    logic [2:0]              r_ecnt;

    // saturate helpers
    function automatic logic signed [PB-1:0] sat_pos(input logic signed [VW-1:0] v);
        logic signed [PB-1:0] s;
        if (v[VW-1:PB-1] == {(VW-PB+1){1'b0}} || v[VW-1:PB-1] == {(VW-PB+1){1'b1}}) begin
            s = v[PB-1:0];
        end else if (v[VW-1]) begin
            s = {1'b1, {(PB-1){1'b0}}};
        end else begin
            s = {1'b0, {(PB-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
        logic signed [31:0] s;
        if (v[CW-1:31] == {(CW-31){1'b0}} || v[CW-1:31] == {(CW-31){1'b1}}) begin
            s = v[31:0];
        end else if (v[CW-1]) begin
            s = {1'b1, {31{1'b0}}};
        end else begin
            s = {1'b0, {31{1'b1}}};
        end
        return s;
    endfunction

    // restoring divider trial step
    logic [CB:0] div_shift;
    logic        div_ge;
    assign div_shift = {r_rem[CB-1:0], (r_dcnt == 5'(ANG_FRAC))};
    assign div_ge    = (div_shift >= {1'b0, r_rad});

    // cordic micro-rotation
    logic signed [CW-1:0] cord_ang;
    logic signed [CW-1:0] cord_xs;
    logic signed [CW-1:0] cord_ys;
    assign cord_ang = (r_iter < IW'(32)) ? CW'(atan_q30(r_iter[4:0])) : '0;
    assign cord_xs  = r_cx >>> r_iter;
    assign cord_ys  = r_cy >>> r_iter;

    // rotation partial product select: tag[2] target, tag[1] operand, tag[0] slice
    logic [2:0]            mul_k;
    logic signed [PB-1:0]  mul_pos;
    logic signed [PLO:0]   mul_a;
    logic signed [31:0]    mul_b;
    logic signed [AW-1:0]  acc_term;
    assign mul_k   = r_step[2:0];
    assign mul_pos = mul_k[1] ? r_pos_y : r_pos_x;
    assign mul_a   = mul_k[0] ? (PLO+1)'($signed(mul_pos[PB-1:PLO]))
                              : $signed({1'b0, mul_pos[PLO-1:0]});
    assign mul_b   = (mul_k[2] ^ mul_k[1]) ? r_sin : r_cos;
    assign acc_term = r_tag[0] ? (AW'(r_prod) <<< PLO) : AW'(r_prod);

    // rounding of the new position
    logic signed [AW-1:0] rnd_x;
    logic signed [AW-1:0] rnd_y;
    assign rnd_x = (r_acc_x + (AW'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
    assign rnd_y = (r_acc_y + (AW'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;

    // pixel rounding
    logic signed [PB:0] half_x;
    logic signed [PB:0] half_y;
    assign half_x = PB'(r_pos_x) + ((PB+1)'(1) <<< (FRAC_BITS - 1));
    assign half_y = PB'(r_pos_y) + ((PB+1)'(1) <<< (FRAC_BITS - 1));

    // octant pixel for the current output slot
    logic signed [OW-1:0] oct_a;
    logic signed [OW-1:0] oct_b;
    logic signed [OW-1:0] pix_x;
    logic signed [OW-1:0] pix_y;
    assign oct_a = OW'(r_ecnt[2] ? r_ry : r_rx);
    assign oct_b = OW'(r_ecnt[2] ? r_rx : r_ry);
    assign pix_x = $signed(OW'(r_ccol)) + (r_ecnt[1] ? -oct_a : oct_a);
    assign pix_y = $signed(OW'(r_crow)) + (r_ecnt[0] ? -oct_b : oct_b);

    logic out_load;
    logic emit_go;
    assign out_load = !o_valid || !i_stall;
    assign emit_go  = out_load && ((r_state == S_EMIT) || (r_state == S_DONE));
    assign o_pop    = (r_state == S_IDLE) && i_item_valid;

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_cos    <= '0;
            r_sin    <= '0;
            r_ccol   <= '0;
            r_crow   <= '0;
            r_pv     <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (emit_go) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.func == FUNC_START) begin
                            r_ccol   <= CB'(i_item.center_x);
                            r_crow   <= CB'(i_item.center_y);
                            r_rad    <= CB'(i_item.radius);
                            r_active <= 1'b1;
                            r_rem    <= '0;
                            r_dcnt   <= 5'(ANG_FRAC);
                            if (CB'(i_item.radius) == '0) begin
                                r_cos   <= $signed(ONE_Q30);
                                r_sin   <= '0;
                                r_pos_x <= '0;
                                r_pos_y <= '0;
                                r_state <= S_RND;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else if (r_active && (r_pos_x > r_pos_y)) begin
                            r_step  <= '0;
                            r_acc_x <= '0;
                            r_acc_y <= '0;
                            r_pv    <= 1'b0;
                            r_state <= S_ROT;
                        end else begin
                            r_active <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? (div_shift - {1'b0, r_rad}) : div_shift;
                    r_quo <= {r_quo[ANG_FRAC-2:0], div_ge};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd0) begin
                        r_cx    <= CW'($signed(CORDIC_GAIN));
                        r_cy    <= '0;
                        r_cz    <= CW'(r_quo[ANG_FRAC-1:0]) <<< 1 | CW'(div_ge);
                        r_iter  <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_iter == IW'(CORDIC_ITERS)) begin
                        r_cos   <= sat32(r_cx);
                        r_sin   <= sat32(r_cy);
                        r_pos_x <= $signed(PB'(r_rad) <<< FRAC_BITS);
                        r_pos_y <= '0;
                        r_state <= S_RND;
                    end else begin
                        if (!r_cz[CW-1]) begin
                            r_cx <= r_cx - cord_ys;
                            r_cy <= r_cy + cord_xs;
                            r_cz <= r_cz - cord_ang;
                        end else begin
                            r_cx <= r_cx + cord_ys;
                            r_cy <= r_cy - cord_xs;
                            r_cz <= r_cz + cord_ang;
                        end
                        r_iter <= r_iter + IW'(1);
                    end
                end
                S_ROT: begin
                    if (!r_step[3]) begin
                        r_prod <= PM'(mul_a * mul_b);
                        r_tag  <= mul_k;
                        r_pv   <= 1'b1;
                        r_step <= r_step + 4'd1;
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_FIN;
                    end
                    if (r_pv) begin
                        if (!r_tag[2]) begin
                            r_acc_x <= r_tag[1] ? r_acc_x - acc_term : r_acc_x + acc_term;
                        end else begin
                            r_acc_y <= r_acc_y + acc_term;
                        end
                    end
                end
                S_FIN: begin
                    r_pos_x <= sat_pos(VW'(rnd_x));
                    r_pos_y <= sat_pos(VW'(rnd_y));
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_rx    <= RW'(half_x >>> FRAC_BITS);
                    r_ry    <= RW'(half_y >>> FRAC_BITS);
                    r_ecnt  <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        o_pixel_x     <= pix_x[12:0];
                        o_pixel_y     <= pix_y[12:0];
                        o_color       <= i_color;
                        o_last_of_run <= (r_ecnt == 3'd7);
                        o_circle_done <= 1'b0;
                        r_ecnt        <= r_ecnt + 3'd1;
                        if (r_ecnt == 3'd7) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        o_pixel_x     <= '0;
                        o_pixel_y     <= '0;
                        o_color       <= '0;
                        o_last_of_run <= 1'b1;
                        o_circle_done <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/polar_circle_point_generator.sv
// advance: one shared rotation multiplier forms the partial products in turn, then eight pixels go out
// start: bit-serial divide, then CORDIC_ITERS cordic steps, one cordic step a cycle
// zero radius start skips divide and cordic
// a two-entry queue lets the front take items while the engine works
// synchronous active-low reset clears control state, circle state and the color register
`timescale 1ns / 1ps
`default_nettype none
module polar_circle_point_generator
    import pcpg_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_func,
    input  wire        [10:0] i_center_x,
    input  wire        [10:0] i_center_y,
    input  wire        [10:0] i_radius,
    input  wire               i_cfg_we,
    input  wire        [23:0] i_cfg_data,
    output logic              o_valid,
    input  wire               i_stall,
    output logic signed [12:0] o_pixel_x,
    output logic signed [12:0] o_pixel_y,
    output logic       [23:0] o_color,
    output logic              o_last_of_run,
    output logic              o_circle_done
);

    logic [23:0] r_pixel_color;
    t_item       front_item;
    t_item       q_item;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        push;

    // color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color <= '0;
        end else if (i_cfg_we) begin
            r_pixel_color <= i_cfg_data;
        end
    end

    // front: take an item and classify it; advance items carry no geometry
    assign o_stall = q_full;
    assign push    = i_valid && !q_full;
    always_comb begin
        front_item.func     = i_func;
        front_item.center_x = (i_func == FUNC_START) ? i_center_x : '0;
        front_item.center_y = (i_func == FUNC_START) ? i_center_y : '0;
        front_item.radius   = (i_func == FUNC_START) ? i_radius : '0;
    end

    pcpg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_valid (q_valid)
    );

    pcpg_engine #(
        .COORD_BITS   (COORD_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_item_valid  (q_valid),
        .o_pop         (q_pop),
        .i_color       (r_pixel_color),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_color       (o_color),
        .o_last_of_run (o_last_of_run),
        .o_circle_done (o_circle_done)
    );

`ifndef SYNTHESIS
    // done marker always closes its run and carries no color
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_circle_done) |-> (o_last_of_run && o_color == 24'd0))
        else $error("done marker without last or with color");

    // done marker pixel fields are zero
    a_done_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_circle_done) |-> (o_pixel_x == 13'sd0 && o_pixel_y == 13'sd0))
        else $error("done marker with pixel");

    // engine never pops an empty queue
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue underrun");
`endif

endmodule
`default_nettype wire

>>> sim/polar_circle_point_generator_tb.sv
// self-checking testbench for the polar circle point generator
`timescale 1ns / 1ps
`default_nettype none
module polar_circle_point_generator_tb;
    import pcpg_pkg::*;

    // one expected pixel or done marker
    typedef struct packed {
        logic [12:0] px;
        logic [12:0] py;
        logic [23:0] col;
        logic        last;
        logic        done;
    } t_pixel;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_CYCLES    = 400;

    // arctangent of 2^-i in q2.30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [10:0] i_center_x = '0;
    logic [10:0] i_center_y = '0;
    logic [10:0] i_radius = '0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [12:0] o_pixel_x;
    logic signed [12:0] o_pixel_y;
    logic [23:0] o_color;
    logic        o_last_of_run;
    logic        o_circle_done;

    polar_circle_point_generator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_radius(i_radius),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y), .o_color(o_color),
        .o_last_of_run(o_last_of_run), .o_circle_done(o_circle_done)
    );

    always #5 i_clk = ~i_clk;

    t_item  pending_items[$];
    t_pixel expected_pixels[$];
    int     pushed_cnt = 0;
    int     accepted_cnt = 0;
    int     pixels_seen = 0;
    int     mismatch_cnt = 0;
    int     quiet_cycles = 0;
    logic   item_taken = 1'b0;
    logic   calm = 1'b0;

    // circle state of the predictor
    logic [23:0] model_color = '0;
    longint      pos_x = 0, pos_y = 0, step_c = 0, step_s = 0;
    longint      ctr_col = 0, ctr_row = 0;
    bit          drawing = 0;

    function automatic longint clamp_bits(longint v, int bits);
        longint lim;
        lim = 64'sd1 <<< (bits - 1);
        if (v >= lim) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void push_pixel(longint px, longint py, logic last);
        t_pixel p;
        p.px = 13'(px);
        p.py = 13'(py);
        p.col = model_color;
        p.last = last;
        p.done = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    // eight octant reflections of the rounded point
    function automatic void emit_octants();
        longint rx, ry;
        rx = (pos_x + (64'sd1 <<< 19)) >>> 20;
        ry = (pos_y + (64'sd1 <<< 19)) >>> 20;
        push_pixel(ctr_col + rx, ctr_row + ry, 1'b0);
        push_pixel(ctr_col + rx, ctr_row - ry, 1'b0);
        push_pixel(ctr_col - rx, ctr_row + ry, 1'b0);
        push_pixel(ctr_col - rx, ctr_row - ry, 1'b0);
        push_pixel(ctr_col + ry, ctr_row + rx, 1'b0);
        push_pixel(ctr_col + ry, ctr_row - rx, 1'b0);
        push_pixel(ctr_col - ry, ctr_row + rx, 1'b0);
        push_pixel(ctr_col - ry, ctr_row - rx, 1'b1);
    endfunction

    function automatic void predict_circle_item(t_item it);
        longint x, y, z, nx, ny, ang, r;
        t_pixel p;
        if (it.func == FUNC_START) begin
            r = longint'(it.radius);
            ctr_col = longint'(it.center_x);
            ctr_row = longint'(it.center_y);
            if (r == 0) begin
                step_c = 64'sd1 <<< 30;
                step_s = 0;
            end else begin
                // fixed-length cordic rotation by 1/r
                x = longint'(CORDIC_GAIN);
                y = 0;
                z = (64'sd1 <<< 30) / r;
                for (int i = 0; i < 32; i++) begin
                    ang = longint'(ATAN_Q30[i]);
                    if (z >= 0) begin
                        nx = x - (y >>> i);
                        y = y + (x >>> i);
                        z = z - ang;
                    end else begin
                        nx = x + (y >>> i);
                        y = y - (x >>> i);
                        z = z + ang;
                    end
                    x = nx;
                end
                step_c = clamp_bits(x, 32);
                step_s = clamp_bits(y, 32);
            end
            pos_x = r <<< 20;
            pos_y = 0;
            drawing = 1;
            emit_octants();
        end else if (drawing && pos_x > pos_y) begin
            nx = (pos_x * step_c - pos_y * step_s + (64'sd1 <<< 29)) >>> 30;
            ny = (pos_x * step_s + pos_y * step_c + (64'sd1 <<< 29)) >>> 30;
            pos_x = clamp_bits(nx, 33);
            pos_y = clamp_bits(ny, 33);
            emit_octants();
        end else begin
            drawing = 0;
            p = '{px: '0, py: '0, col: '0, last: 1'b1, done: 1'b1};
            expected_pixels.push_back(p);
        end
    endfunction

    // input side: accept and predict
    always @(posedge i_clk) begin
        item_taken <= i_valid && !o_stall && i_rst_n;
        if (i_rst_n && i_valid && !o_stall) begin
            predict_circle_item('{i_func, i_center_x, i_center_y, i_radius});
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    // driver: next item at the falling edge
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!i_valid || item_taken)) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_func <= it.func;
                i_center_x <= it.center_x;
                i_center_y <= it.center_y;
                i_radius <= it.radius;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!hold_done && pixels_seen >= 150) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result x=%0d y=%0d col=%h last=%b done=%b",
                             o_pixel_x, o_pixel_y, o_color, o_last_of_run, o_circle_done);
            end else begin
                want = expected_pixels.pop_front();
                if (want.px !== o_pixel_x || want.py !== o_pixel_y
                        || want.col !== o_color || want.last !== o_last_of_run
                        || want.done !== o_circle_done) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch exp x=%0d y=%0d col=%h last=%b done=%b got x=%0d y=%0d col=%h last=%b done=%b",
                                 $signed(want.px), $signed(want.py), want.col, want.last,
                                 want.done, o_pixel_x, o_pixel_y, o_color,
                                 o_last_of_run, o_circle_done);
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic add_item(logic f, logic [10:0] cx, logic [10:0] cy, logic [10:0] r);
        pending_items.push_back('{f, cx, cy, r});
        pushed_cnt++;
    endtask

    // start plus a run of advances, mostly small circles
    task automatic add_circle_run();
        int r, steps;
        if ($urandom_range(9) == 0) begin
            r = $urandom_range(2047);
            steps = $urandom_range(4);
        end else begin
            r = $urandom_range(1, 30);
            steps = $urandom_range(r * 4 / 5 + 3);
            if (steps > 24) steps = 24;
        end
        add_item(FUNC_START, 11'($urandom), 11'($urandom), 11'(r));
        for (int k = 0; k < steps; k++)
            add_item(FUNC_ADVANCE, 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (accepted_cnt != pushed_cnt || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_color(logic [23:0] c);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= c;
        model_color = c;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and special cases, reset color
        add_item(FUNC_ADVANCE, 11'h7FF, 11'h7FF, 11'h7FF);
        add_item(FUNC_START, 11'h000, 11'h000, 11'h000);
        add_item(FUNC_ADVANCE, 11'h000, 11'h000, 11'h000);
        add_item(FUNC_ADVANCE, 11'h000, 11'h000, 11'h000);
        add_item(FUNC_START, 11'h7FF, 11'h7FF, 11'h7FF);
        add_item(FUNC_ADVANCE, 11'h000, 11'h000, 11'h000);
        add_item(FUNC_ADVANCE, 11'h7FF, 11'h7FF, 11'h7FF);
        add_item(FUNC_START, 11'h000, 11'h7FF, 11'h001);
        for (int k = 0; k < 3; k++)
            add_item(FUNC_ADVANCE, 11'h555, 11'h2AA, 11'h555);
        add_item(FUNC_START, 11'h7FF, 11'h000, 11'h002);
        for (int k = 0; k < 4; k++)
            add_item(FUNC_ADVANCE, 11'h2AA, 11'h555, 11'h2AA);
        wait_idle();

        // all-ones color, no idling, then a full pause
        write_color(24'hFFFFFF);
        calm = 1'b1;
        while (pushed_cnt < 120) add_circle_run();
        wait_idle();
        calm = 1'b0;

        // random color and random gaps
        write_color(24'($urandom));
        while (pushed_cnt < 300) begin
            if ($urandom_range(9) == 0)
                add_item(1'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
            else
                add_circle_run();
        end
        wait_idle();

        // back to zero color
        write_color(24'h000000);
        while (pushed_cnt < 460) begin
            if ($urandom_range(9) == 0)
                add_item(1'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
            else
                add_circle_run();
        end
        wait_idle();

        if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
